[hw/rtl/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg: shared definitions of the multichannel moving average
// Sizes, register indexes, command and result word types used by the
// front queue, the filter engine and the result queue.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int CHANNELS    = 4;
  localparam int WINDOW_MAX  = 32;
  localparam int OFFSET_REGS = 4;

  localparam int DATA_W      = 32;
  localparam int SUM_W       = 38;
  localparam int EXT_W       = SUM_W - DATA_W;
  localparam int CH_IN_W     = 3;
  localparam int WIN_FIELD_W = 6;
  localparam int CFG_IDX_W   = 3;

  localparam int WIN_W      = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OFS_W      = $clog2(OFFSET_REGS);
  localparam int ADDR_W     = CH_W + IDX_W;
  localparam int RING_DEPTH = (2 ** CH_W) * (2 ** IDX_W);
  localparam int CNT_W      = $clog2(SUM_W + 1);

  localparam int WINDOW_RESET = (8 > WINDOW_MAX) ? WINDOW_MAX : 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET0 = 3'd1;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    KIND_FILTER,
    KIND_PASS,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      ch_ok;
    logic [CH_IN_W-1:0]        channel;
    logic signed [DATA_W-1:0]  sample;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered;
    logic signed [DATA_W-1:0] average;
    logic                     has_samples;
  } result_t;

endpackage

[hw/rtl/mma_front.sv]
// ----------------------------------------------------------------------------
// mma_front: input queue and classifier
// Accepts input words, sorts each into filter, pass-through or clear, and
// holds up to two classified words for the filter engine.
// ----------------------------------------------------------------------------
module mma_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              opcode,
  input  logic [mma_pkg::CH_IN_W-1:0]       channel,
  input  logic signed [mma_pkg::DATA_W-1:0] sample,
  output logic                              cmd_valid,
  output mma_pkg::cmd_t                     cmd,
  input  logic                              cmd_take
);

  mma_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  mma_pkg::cmd_t in_cmd;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    in_cmd.ch_ok   = (32'(channel) < mma_pkg::CHANNELS);
    in_cmd.channel = channel;
    in_cmd.sample  = sample;
    if (opcode == mma_pkg::OP_CLEAR) begin
      in_cmd.kind = mma_pkg::KIND_CLEAR;
    end else if (in_cmd.ch_ok) begin
      in_cmd.kind = mma_pkg::KIND_FILTER;
    end else begin
      in_cmd.kind = mma_pkg::KIND_PASS;
    end
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        q[wr_ptr] <= in_cmd;
        wr_ptr    <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/mma_divider.sv]
// ----------------------------------------------------------------------------
// mma_divider: radix-2 signed divider
// Divides the running sum by the fill count one quotient bit per cycle and
// truncates toward zero.
// ----------------------------------------------------------------------------
module mma_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [mma_pkg::SUM_W-1:0] dividend,
  input  logic [mma_pkg::WIN_W-1:0]        divisor,
  output logic                             done,
  output logic [mma_pkg::SUM_W-1:0]        quotient
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } dstate_t;

  dstate_t                    state;
  logic [mma_pkg::CNT_W-1:0]  cnt;
  logic [mma_pkg::SUM_W-1:0]  quo;
  logic [mma_pkg::WIN_W-1:0]  rem;
  logic [mma_pkg::WIN_W-1:0]  dvs;
  logic                       neg;
  logic [mma_pkg::WIN_W:0]    rem_sh;
  logic [mma_pkg::WIN_W:0]    rem_sub;
  logic                       ge;

  always_comb begin
    rem_sh  = {rem, quo[mma_pkg::SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    ge      = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            quo   <= dividend[mma_pkg::SUM_W-1] ? -dividend : dividend;
            neg   <= dividend[mma_pkg::SUM_W-1];
            rem   <= '0;
            dvs   <= divisor;
            cnt   <= mma_pkg::CNT_W'(mma_pkg::SUM_W);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          quo <= {quo[mma_pkg::SUM_W-2:0], ge};
          rem <= ge ? rem_sub[mma_pkg::WIN_W-1:0] : rem_sh[mma_pkg::WIN_W-1:0];
          cnt <= cnt - 1'b1;
          if (cnt == mma_pkg::CNT_W'(1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          quotient <= neg ? -quo : quo;
          done     <= 1'b1;
          state    <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/mma_back.sv]
// ----------------------------------------------------------------------------
// mma_back: filter engine
// Holds the configuration, the per-channel ring, index, count and sum, and
// carries out one classified word at a time into a result word.
// ----------------------------------------------------------------------------
module mma_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mma_pkg::DATA_W-1:0]           cfg_data,
  input  logic                                 cmd_valid,
  input  mma_pkg::cmd_t                        cmd,
  output logic                                 cmd_take,
  input  logic                                 res_full,
  output logic                                 res_push,
  output mma_pkg::result_t                     res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_ADD,
    S_DIV,
    S_SAT
  } state_t;

  state_t                              state;
  logic [mma_pkg::WIN_W-1:0]           window;
  logic signed [mma_pkg::DATA_W-1:0]   offsets  [mma_pkg::OFFSET_REGS];
  logic [mma_pkg::IDX_W-1:0]           wr_idx   [mma_pkg::CHANNELS];
  logic [mma_pkg::WIN_W-1:0]           fill     [mma_pkg::CHANNELS];
  logic signed [mma_pkg::SUM_W-1:0]    sum      [mma_pkg::CHANNELS];
  logic [mma_pkg::DATA_W-1:0]          ring     [mma_pkg::RING_DEPTH];
  logic [mma_pkg::DATA_W-1:0]          ram_q;

  logic [mma_pkg::CH_W-1:0]            cur_ch;
  logic signed [mma_pkg::DATA_W-1:0]   cur_sample;
  logic [mma_pkg::IDX_W-1:0]           cur_slot;
  logic                                cur_full;
  logic signed [mma_pkg::SUM_W-1:0]    sum_work;
  logic signed [mma_pkg::DATA_W-1:0]   avg;

  logic [mma_pkg::CH_W-1:0]            cmd_ch;
  logic [mma_pkg::IDX_W-1:0]           cmd_slot;
  logic                                cmd_full;
  logic [mma_pkg::ADDR_W-1:0]          rd_addr;
  logic [mma_pkg::WIN_W-1:0]           slot_inc;
  logic [mma_pkg::IDX_W-1:0]           next_slot;
  logic [mma_pkg::WIN_W-1:0]           fill_new;
  logic signed [mma_pkg::SUM_W-1:0]    sum_new;
  logic signed [mma_pkg::SUM_W-1:0]    old_ext;
  logic [mma_pkg::WIN_FIELD_W-1:0]     w_in;
  logic [mma_pkg::WIN_W-1:0]           w_clamp;
  logic [mma_pkg::CFG_IDX_W-1:0]       ofs_sel;
  logic signed [mma_pkg::DATA_W:0]     diff;
  logic signed [mma_pkg::DATA_W-1:0]   diff_sat;
  logic signed [mma_pkg::DATA_W-1:0]   cur_offset;
  logic                                div_start;
  logic                                div_done;
  logic [mma_pkg::SUM_W-1:0]           div_quot;

  always_comb begin
    cmd_ch   = cmd.channel[mma_pkg::CH_W-1:0];
    cmd_slot = (mma_pkg::WIN_W'(wr_idx[cmd_ch]) >= window) ? '0 : wr_idx[cmd_ch];
    cmd_full = (fill[cmd_ch] >= window);
    rd_addr  = {cmd_ch, cmd_slot};

    slot_inc  = mma_pkg::WIN_W'(cur_slot) + 1'b1;
    next_slot = (slot_inc >= window) ? '0 : slot_inc[mma_pkg::IDX_W-1:0];
    fill_new  = cur_full ? fill[cur_ch] : fill[cur_ch] + 1'b1;
    sum_new   = sum_work + {{mma_pkg::EXT_W{cur_sample[mma_pkg::DATA_W-1]}}, cur_sample};
    old_ext   = cur_full ? {{mma_pkg::EXT_W{ram_q[mma_pkg::DATA_W-1]}}, ram_q} : '0;

    w_in = cfg_data[mma_pkg::WIN_FIELD_W-1:0];
    if (w_in == '0) begin
      w_clamp = mma_pkg::WIN_W'(1);
    end else if (32'(w_in) > mma_pkg::WINDOW_MAX) begin
      w_clamp = mma_pkg::WIN_W'(mma_pkg::WINDOW_MAX);
    end else begin
      w_clamp = mma_pkg::WIN_W'(w_in);
    end
    ofs_sel = cfg_index - mma_pkg::REG_OFFSET0;

    cur_offset = offsets[mma_pkg::OFS_W'(cur_ch)];
    diff       = {avg[mma_pkg::DATA_W-1], avg} - {cur_offset[mma_pkg::DATA_W-1], cur_offset};
    if (diff[mma_pkg::DATA_W] != diff[mma_pkg::DATA_W-1]) begin
      diff_sat = diff[mma_pkg::DATA_W] ? {1'b1, {(mma_pkg::DATA_W-1){1'b0}}}
                                       : {1'b0, {(mma_pkg::DATA_W-1){1'b1}}};
    end else begin
      diff_sat = diff[mma_pkg::DATA_W-1:0];
    end
  end

  assign cmd_take  = (state == S_IDLE) && cmd_valid && !res_full && !res_push;
  assign div_start = (state == S_ADD);

  mma_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (fill_new),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (state == S_ADD) begin
      ring[{cur_ch, cur_slot}] <= cur_sample;
    end
    ram_q <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_push <= 1'b0;
      window   <= mma_pkg::WIN_W'(mma_pkg::WINDOW_RESET);
      for (int i = 0; i < mma_pkg::OFFSET_REGS; i++) begin
        offsets[i] <= '0;
      end
      for (int c = 0; c < mma_pkg::CHANNELS; c++) begin
        wr_idx[c] <= '0;
        fill[c]   <= '0;
        sum[c]    <= '0;
      end
    end else begin
      res_push <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          mma_pkg::REG_WINDOW: begin
            if (w_clamp != window) begin
              window <= w_clamp;
              for (int c = 0; c < mma_pkg::CHANNELS; c++) begin
                wr_idx[c] <= '0;
                fill[c]   <= '0;
                sum[c]    <= '0;
              end
            end
          end
          default: begin
            if (32'(ofs_sel) < mma_pkg::OFFSET_REGS) begin
              offsets[ofs_sel[mma_pkg::OFS_W-1:0]] <= cfg_data;
            end
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            case (cmd.kind)
              mma_pkg::KIND_CLEAR: begin
                if (cmd.ch_ok) begin
                  wr_idx[cmd_ch] <= '0;
                  fill[cmd_ch]   <= '0;
                  sum[cmd_ch]    <= '0;
                end
                res      <= '0;
                res_push <= 1'b1;
              end
              mma_pkg::KIND_PASS: begin
                res.filtered    <= cmd.sample;
                res.average     <= '0;
                res.has_samples <= 1'b0;
                res_push        <= 1'b1;
              end
              default: begin
                cur_ch     <= cmd_ch;
                cur_sample <= cmd.sample;
                cur_slot   <= cmd_slot;
                cur_full   <= cmd_full;
                state      <= S_SUB;
              end
            endcase
          end
        end
        S_SUB: begin
          sum_work <= sum[cur_ch] - old_ext;
          state    <= S_ADD;
        end
        S_ADD: begin
          sum[cur_ch]    <= sum_new;
          wr_idx[cur_ch] <= next_slot;
          fill[cur_ch]   <= fill_new;
          state          <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            avg   <= div_quot[mma_pkg::DATA_W-1:0];
            state <= S_SAT;
          end
        end
        S_SAT: begin
          res.filtered    <= diff_sat;
          res.average     <= avg;
          res.has_samples <= 1'b1;
          res_push        <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/mma_outq.sv]
// ----------------------------------------------------------------------------
// mma_outq: result queue
// Two-entry queue that holds finished result words until they are popped.
// ----------------------------------------------------------------------------
module mma_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  mma_pkg::result_t res,
  output logic             res_full,
  output logic             empty,
  input  logic             pop,
  output mma_pkg::result_t head
);

  mma_pkg::result_t q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = q[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        q[wr_ptr] <= res;
        wr_ptr    <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/multichannel_moving_average.sv]
// ----------------------------------------------------------------------------
// multichannel_moving_average: per-channel boxcar averaging filter
// Input words arrive on a queue port: a word is taken when push is high and
// full is low. Each word either filters a sample on one of four channels,
// clears a channel if in range, or passes a sample through on a channel out of range.
// Result words leave on a queue port: the oldest result is on filtered,
// average and has_samples while empty is low and is taken when pop is high.
// A filter word runs through the subtract, add, divide and saturate states;
// the radix-2 divider produces one quotient bit per cycle of the 38-bit
// running sum. Clear and pass-through words are answered from the idle state.
// Words are carried out one at a time, so the engine takes no new word until
// the last one is finished and its result pushed; a two-entry queue on each
// side lets the next input word wait while a result is still waiting to be
// popped. When pop stays low the result queue fills, the engine holds, and
// full rises once the input queue fills. Reset empties both queues, clears
// every channel and sets the window to 8 and all offsets to 0. Configuration
// must be written through cfg_write, cfg_index and cfg_data only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multichannel_moving_average (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 opcode,
  input  logic [mma_pkg::CH_IN_W-1:0]          channel,
  input  logic signed [mma_pkg::DATA_W-1:0]    sample,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [mma_pkg::DATA_W-1:0]    filtered,
  output logic signed [mma_pkg::DATA_W-1:0]    average,
  output logic                                 has_samples,
  input  logic                                 cfg_write,
  input  logic [mma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mma_pkg::DATA_W-1:0]           cfg_data
);

  logic             cmd_valid;
  mma_pkg::cmd_t    cmd;
  logic             cmd_take;
  logic             res_full;
  logic             res_push;
  mma_pkg::result_t res;
  mma_pkg::result_t head;

  mma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .channel   (channel),
    .sample    (sample),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  mma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  mma_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign filtered    = head.filtered;
  assign average     = head.average;
  assign has_samples = head.has_samples;

endmodule
